/* src/assert_macros.svh */
// Assertion macros shared by the integer to ASCII formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define I2A_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define I2A_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/i2a_pkg.sv */
// Types, constants and helper functions of the integer to ASCII formatter.
package i2a_pkg;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2
  } radix_t;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_MINUS = 2'd2
  } sign_t;

  localparam int unsigned NUM_DIGITS    = 22;
  localparam int unsigned BCD_DIGITS    = 20;
  localparam int unsigned STEPS_PER_STG = 8;
  localparam int unsigned DABBLE_STAGES = 64 / STEPS_PER_STG;

  localparam logic [4:0] WIDTH_DEC = 5'd19;
  localparam logic [4:0] WIDTH_HEX = 5'd16;
  localparam logic [4:0] WIDTH_OCT = 5'd22;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic        upper_case;
    logic [4:0]  min_digits;
    logic [4:0]  max_digits;
    logic        show_plus;
    logic        is_unsigned;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_t;

  // Payload that travels through the conversion stages.
  typedef struct packed {
    radix_t                      radix;
    logic                        upper;
    sign_t                       sign;
    logic [4:0]                  mn;
    logic [4:0]                  mx;
    logic [63:0]                 raw;
    logic [BCD_DIGITS*4-1:0]     bcd;
    logic [63:0]                 bin;
  } pipe_t;

  // Payload handed to the character serialiser.
  typedef struct packed {
    radix_t                      radix;
    logic                        upper;
    sign_t                       sign;
    logic [4:0]                  start;
    logic [NUM_DIGITS-1:0][3:0]  digs;
  } fmt_t;

  // One double-dabble step: correct every BCD digit, then shift one bit in.
  function automatic logic [BCD_DIGITS*4+63:0] dabble_step(
    input logic [BCD_DIGITS*4+63:0] x
  );
    logic [BCD_DIGITS*4+63:0] y;
    y = x;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (y[64+4*d +: 4] >= 4'd5) begin
        y[64+4*d +: 4] = y[64+4*d +: 4] + 4'd3;
      end
    end
    return {y[BCD_DIGITS*4+62:0], 1'b0};
  endfunction

  function automatic logic [7:0] digit_char(
    input radix_t     radix,
    input logic       upper,
    input logic [3:0] d
  );
    logic [7:0] c;
    if (radix == RADIX_HEX && d >= 4'd10) begin
      c = (upper ? CHAR_UP_A : CHAR_LOW_A) + {4'd0, d - 4'd10};
    end else begin
      c = CHAR_ZERO + {4'd0, d};
    end
    return c;
  endfunction

endpackage

/* src/i2a_prep.sv */
// Input stage: digit count clamps, sign decision and magnitude.
module i2a_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  i2a_pkg::in_t     in_item,
  output logic             out_valid_r,
  output i2a_pkg::pipe_t   out_p_r
);

  i2a_pkg::pipe_t p_nxt;
  logic [4:0]     width;
  logic [4:0]     mn;
  logic [4:0]     mx;
  logic           neg;

  always_comb begin
    p_nxt = '0;
    case (in_item.op)
      i2a_pkg::RADIX_HEX: p_nxt.radix = i2a_pkg::RADIX_HEX;
      i2a_pkg::RADIX_OCT: p_nxt.radix = i2a_pkg::RADIX_OCT;
      default:            p_nxt.radix = i2a_pkg::RADIX_DEC;
    endcase
    case (p_nxt.radix)
      i2a_pkg::RADIX_HEX: width = i2a_pkg::WIDTH_HEX;
      i2a_pkg::RADIX_OCT: width = i2a_pkg::WIDTH_OCT;
      default:            width = i2a_pkg::WIDTH_DEC;
    endcase
    if (in_item.min_digits == 5'd0) mn = 5'd1;
    else if (in_item.min_digits > width) mn = width;
    else mn = in_item.min_digits;
    if (in_item.max_digits == 5'd0) begin
      mx = (p_nxt.radix == i2a_pkg::RADIX_DEC) ? i2a_pkg::WIDTH_DEC : 5'd1;
    end else if (in_item.max_digits > width) begin
      mx = width;
    end else begin
      mx = in_item.max_digits;
    end
    if (mn > mx) mx = mn;
    neg = !in_item.is_unsigned && in_item.value[63];
    p_nxt.upper = in_item.upper_case;
    p_nxt.mn    = mn;
    p_nxt.mx    = mx;
    p_nxt.raw   = in_item.value;
    p_nxt.sign  = i2a_pkg::SIGN_NONE;
    p_nxt.bin   = in_item.value;
    if (p_nxt.radix == i2a_pkg::RADIX_DEC) begin
      if (in_item.show_plus && !neg) begin
        p_nxt.sign = i2a_pkg::SIGN_PLUS;
      end else if (neg) begin
        p_nxt.sign = i2a_pkg::SIGN_MINUS;
        p_nxt.bin  = 64'd0 - in_item.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_p_r <= p_nxt;
    end
  end

endmodule

/* src/i2a_dabble_stage.sv */
// One binary to BCD stage: eight double-dabble steps and a register.
module i2a_dabble_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  i2a_pkg::pipe_t   in_p,
  output logic             out_valid_r,
  output i2a_pkg::pipe_t   out_p_r
);

  i2a_pkg::pipe_t                      p_nxt;
  logic [i2a_pkg::BCD_DIGITS*4+63:0]   acc;

  always_comb begin
    acc = {in_p.bcd, in_p.bin};
    for (int s = 0; s < i2a_pkg::STEPS_PER_STG; s++) begin
      acc = i2a_pkg::dabble_step(acc);
    end
    p_nxt     = in_p;
    p_nxt.bcd = acc[i2a_pkg::BCD_DIGITS*4+63:64];
    p_nxt.bin = acc[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_p_r <= p_nxt;
    end
  end

endmodule

/* src/i2a_format.sv */
// Digit layout per radix and search for the first character to emit.
module i2a_format (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  i2a_pkg::pipe_t   in_p,
  output logic             out_valid_r,
  output i2a_pkg::fmt_t    out_f_r
);

  i2a_pkg::fmt_t                  f_nxt;
  logic [i2a_pkg::NUM_DIGITS-1:0] nz;
  logic [4:0]                     hp;
  logic [4:0]                     lim;

  always_comb begin
    f_nxt       = '0;
    f_nxt.radix = in_p.radix;
    f_nxt.upper = in_p.upper;
    f_nxt.sign  = in_p.sign;
    nz          = '0;
    for (int k = 0; k < i2a_pkg::NUM_DIGITS; k++) begin
      case (in_p.radix)
        i2a_pkg::RADIX_HEX: begin
          if (k < 16) f_nxt.digs[k] = in_p.raw[4*k +: 4];
        end
        i2a_pkg::RADIX_OCT: begin
          if (k < 21) f_nxt.digs[k] = {1'b0, in_p.raw[3*k +: 3]};
          else f_nxt.digs[k] = {3'd0, in_p.raw[63]};
        end
        default: begin
          if (k < 19) f_nxt.digs[k] = in_p.bcd[4*k +: 4];
        end
      endcase
      nz[k] = (f_nxt.digs[k] != 4'd0);
    end
    // The decimal top position is the quotient by 10^18, which may reach 18.
    if (in_p.radix == i2a_pkg::RADIX_DEC) begin
      nz[18] = (in_p.bcd[75:72] != 4'd0) || (in_p.bcd[79:76] != 4'd0);
    end
    hp = 5'd0;
    for (int k = 0; k < i2a_pkg::NUM_DIGITS; k++) begin
      if (nz[k]) hp = 5'(k + 1);
    end
    lim         = (hp < in_p.mx) ? hp : in_p.mx;
    f_nxt.start = (lim > in_p.mn) ? lim : in_p.mn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_f_r <= f_nxt;
    end
  end

endmodule

/* src/i2a_serializer.sv */
// Character serialiser: sign first, then one digit per cycle.
module i2a_serializer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  i2a_pkg::fmt_t   in_f,
  output logic            free,
  output logic            out_valid,
  output i2a_pkg::out_t   out_item
);

  logic                                active_r, active_nxt;
  i2a_pkg::sign_t                      sign_r, sign_nxt;
  logic [4:0]                          pos_r, pos_nxt;
  i2a_pkg::radix_t                     radix_r;
  logic                                upper_r;
  logic [i2a_pkg::NUM_DIGITS-1:0][3:0] digs_r;
  logic [4:0]                          idx;

  assign free      = !active_r || (sign_r == i2a_pkg::SIGN_NONE && pos_r == 5'd1);
  assign out_valid = active_r;
  assign idx       = pos_r - 5'd1;

  always_comb begin
    out_item.last = (sign_r == i2a_pkg::SIGN_NONE) && (pos_r == 5'd1);
    case (sign_r)
      i2a_pkg::SIGN_PLUS:  out_item.out_char = i2a_pkg::CHAR_PLUS;
      i2a_pkg::SIGN_MINUS: out_item.out_char = i2a_pkg::CHAR_MINUS;
      default: out_item.out_char = i2a_pkg::digit_char(radix_r, upper_r, digs_r[idx]);
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    sign_nxt   = sign_r;
    pos_nxt    = pos_r;
    if (active_r) begin
      if (sign_r != i2a_pkg::SIGN_NONE) begin
        sign_nxt = i2a_pkg::SIGN_NONE;
      end else begin
        pos_nxt = pos_r - 5'd1;
        if (pos_r == 5'd1) active_nxt = 1'b0;
      end
    end
    if (load) begin
      active_nxt = 1'b1;
      sign_nxt   = in_f.sign;
      pos_nxt    = in_f.start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      sign_r   <= i2a_pkg::SIGN_NONE;
      pos_r    <= 5'd1;
    end else begin
      active_r <= active_nxt;
      sign_r   <= sign_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      radix_r <= in_f.radix;
      upper_r <= in_f.upper;
      digs_r  <= in_f.digs;
    end
  end

endmodule

/* src/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII formatter.
//
//   Channel  Ports                   Transaction taken when
//   input    start, busy, in_item    start high and busy low at a rising edge
//   result   out_valid, out_item     out_valid high at a rising edge
//
// A transaction passes a preparation stage, eight binary to BCD stages of
// eight double-dabble steps each and a formatting stage before the serialiser
// loads it, each stage registering it, and the serialiser drives its first
// character from its registers onto the result ports.
// The serialiser then sends one character per cycle, 1 to 22 per
// transaction, and when the next transaction already waits formatted, its
// first character follows directly on the cycle after the last one. The
// sustained rate is thus set by the serialiser and the characters it sends.
// Reset is synchronous and active low and clears only the valid bits and the
// serialiser control. While the serialiser is busy and a formatted
// transaction waits, every stage holds and busy is high; the receiver
// cannot stall, so nothing else holds the pipeline.
module integer_to_ascii_formatter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  i2a_pkg::in_t   in_item,
  output logic           out_valid,
  output i2a_pkg::out_t  out_item
);

  `include "assert_macros.svh"

  logic                 adv;
  logic                 prep_valid;
  i2a_pkg::pipe_t       prep_p;
  logic                 dd_valid [i2a_pkg::DABBLE_STAGES+1];
  i2a_pkg::pipe_t       dd_p     [i2a_pkg::DABBLE_STAGES+1];
  logic                 fmt_valid;
  i2a_pkg::fmt_t        fmt_f;
  logic                 ser_free;

  // The whole pipeline moves together unless a formatted transaction is
  // waiting for the serialiser.
  assign adv  = !fmt_valid || ser_free;
  assign busy = !adv;

  i2a_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (start),
    .in_item     (in_item),
    .out_valid_r (prep_valid),
    .out_p_r     (prep_p)
  );

  assign dd_valid[0] = prep_valid;
  assign dd_p[0]     = prep_p;

  for (genvar g = 0; g < i2a_pkg::DABBLE_STAGES; g++) begin : g_dabble
    i2a_dabble_stage u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (adv),
      .in_valid    (dd_valid[g]),
      .in_p        (dd_p[g]),
      .out_valid_r (dd_valid[g+1]),
      .out_p_r     (dd_p[g+1])
    );
  end

  i2a_format u_format (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (dd_valid[i2a_pkg::DABBLE_STAGES]),
    .in_p        (dd_p[i2a_pkg::DABBLE_STAGES]),
    .out_valid_r (fmt_valid),
    .out_f_r     (fmt_f)
  );

  // The serialiser takes a formatted transaction as soon as it is free.
  i2a_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fmt_valid && ser_free),
    .in_f      (fmt_f),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An accepted transaction always reaches the first stage.
  `I2A_ASSERT_NEXT(a_accept_enters, start && !busy, prep_valid)
  // The characters of one transaction leave on consecutive cycles.
  `I2A_ASSERT_NEXT(a_chars_contiguous, out_valid && !out_item.last, out_valid)
  // A waiting formatted transaction is held unchanged.
  `I2A_ASSERT_NEXT(a_hold_on_stall, fmt_valid && !ser_free, fmt_valid && $stable(fmt_f))
  // The block is only ever busy while a formatted transaction waits.
  `I2A_ASSERT_NOW(a_busy_cause, busy, fmt_valid && out_valid)

endmodule

/* tb/integer_to_ascii_formatter_test.sv */
// Self-checking testbench for the integer to ASCII formatter.
module integer_to_ascii_formatter_test;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  i2a_pkg::in_t   in_item;
  logic           out_valid;
  i2a_pkg::out_t  out_item;

  // Characters still owed by the block, oldest first.
  i2a_pkg::out_t  pending_chars[$];
  int             error_count;
  int             cycle_count;

  localparam int CYCLE_LIMIT = 400000;

  integer_to_ascii_formatter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Works out the characters that one transaction should produce, mirroring
  // the digit selection and sign rules of the formatter.
  function automatic void format_value(input i2a_pkg::in_t req,
                                       ref i2a_pkg::out_t chars[$]);
    int             width;
    int             mn;
    int             mx;
    logic [63:0]    mag;
    logic [63:0]    scale;
    logic [63:0]    q;
    logic [7:0]     digs[22];
    logic [7:0]     c;
    bit             seen;
    i2a_pkg::out_t  r;
    logic [7:0]     text[$];
    int             pos;
    if (req.op == i2a_pkg::RADIX_HEX) begin
      width = 16;
    end else if (req.op == i2a_pkg::RADIX_OCT) begin
      width = 22;
    end else begin
      width = 19;
    end
    mn = (req.min_digits < 1) ? 1 : (req.min_digits > width) ? width : req.min_digits;
    if (req.max_digits == 0) begin
      mx = (width == 19) ? 19 : 1;
    end else begin
      mx = (req.max_digits > width) ? width : req.max_digits;
    end
    if (mn > mx) mx = mn;
    mag = req.value;
    if (width == 16) begin
      for (int i = 0; i < 16; i++) digs[i] = {4'd0, mag[60-4*i +: 4]};
    end else if (width == 22) begin
      for (int i = 0; i < 22; i++) digs[i] = 8'((mag >> (63 - 3*i)) & 64'h7);
    end else begin
      if (req.show_plus && (req.is_unsigned || !mag[63])) begin
        text.push_back(i2a_pkg::CHAR_PLUS);
      end else if (!req.is_unsigned && mag[63]) begin
        mag = -mag;
        text.push_back(i2a_pkg::CHAR_MINUS);
      end
      scale = 64'd1000000000000000000;
      for (int i = 0; i < 19; i++) begin
        q = mag / scale;
        mag = mag - q * scale;
        digs[i] = q[7:0];
        scale = scale / 64'd10;
      end
    end
    seen = 1'b0;
    for (int i = 0; i < width; i++) begin
      pos = width - i;
      seen = seen || (digs[i] != 0);
      if ((pos <= mx && seen) || pos <= mn) begin
        if (width == 19) begin
          c = 8'h30 + 8'(digs[i] % 8'd10);
        end else if (digs[i] >= 8'd10) begin
          c = (req.upper_case ? 8'h41 : 8'h61) + digs[i] - 8'd10;
        end else begin
          c = 8'h30 + digs[i];
        end
        text.push_back(c);
      end
    end
    foreach (text[i]) begin
      r.out_char = text[i];
      r.last     = (i == text.size() - 1);
      chars.push_back(r);
    end
  endfunction

  // Compares every character strobe with the oldest owed character.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h", out_item.out_char));
      end else begin
        if (out_item.out_char !== pending_chars[0].out_char) begin
          report_mismatch($sformatf("char %h, expected %h",
            out_item.out_char, pending_chars[0].out_char));
        end
        if (out_item.last !== pending_chars[0].last) begin
          report_mismatch($sformatf("last %b, expected %b",
            out_item.last, pending_chars[0].last));
        end
        void'(pending_chars.pop_front());
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_to_ascii_formatter test failed");
      $finish;
    end
  end

  // Directed row: the request and, where obvious, the text it must yield.
  typedef struct {
    i2a_pkg::in_t req;
    string        text;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic i2a_pkg::in_t make_req(input logic [1:0] op, input logic [63:0] v,
                                            input logic up, input logic [4:0] mn,
                                            input logic [4:0] mx, input logic pl,
                                            input logic us);
    i2a_pkg::in_t r;
    r.op = op; r.value = v; r.upper_case = up; r.min_digits = mn;
    r.max_digits = mx; r.show_plus = pl; r.is_unsigned = us;
    return r;
  endfunction

  // Random request; min_digits spans the full range, max_digits is mostly 22 and sometimes the full range.
  function automatic i2a_pkg::in_t random_req();
    i2a_pkg::in_t r;
    r.op = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: r.value = {$urandom, $urandom};
      1: r.value = 64'($urandom_range(0, 1000));
      2: r.value = -64'($urandom_range(0, 1000));
      default: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    r.upper_case  = 1'($urandom_range(0, 1));
    r.min_digits  = 5'($urandom_range(0, 31));
    r.max_digits  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'd22;
    r.show_plus   = 1'($urandom_range(0, 1));
    r.is_unsigned = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Places one transaction, with a random gap beforehand, and waits for it
  // to be taken. Expectations are queued at the accepting edge. Start is
  // only dropped when a gap follows, so back-to-back requests keep it high.
  task automatic send_request(input i2a_pkg::in_t req, input string text);
    int            gap;
    i2a_pkg::out_t owed[$];
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
        : ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    format_value(req, owed);
    if (text.len() != 0) begin
      if (text.len() != owed.size()) begin
        report_mismatch($sformatf("row text %s length differs from prediction", text));
      end
      foreach (owed[i]) begin
        if (i < text.len()) owed[i].out_char = text[i];
      end
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    foreach (owed[i]) pending_chars.push_back(owed[i]);
  endtask

  initial begin
    int drain;
    error_count = 0;
    cycle_count = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    directed_rows = '{
      '{make_req(i2a_pkg::RADIX_DEC, 64'd0, 0, 0, 0, 0, 0), "0"},
      '{make_req(i2a_pkg::RADIX_DEC, 64'd0, 0, 0, 0, 1, 0), "+0"},
      '{make_req(i2a_pkg::RADIX_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0), "-1"},
      '{make_req(i2a_pkg::RADIX_DEC, 64'h8000_0000_0000_0000, 0, 0, 0, 1, 0),
        "-9223372036854775808"},
      // Unsigned maximum: the top quotient is 18 and prints as its last digit.
      '{make_req(i2a_pkg::RADIX_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 1, 1),
        "+8446744073709551615"},
      '{make_req(i2a_pkg::RADIX_DEC, 64'd42, 0, 5, 0, 0, 0), "00042"},
      '{make_req(i2a_pkg::RADIX_DEC, 64'd12345, 0, 0, 3, 0, 0), "345"},
      '{make_req(i2a_pkg::RADIX_DEC, 64'd7, 0, 31, 31, 0, 1), "0000000000000000007"},
      '{make_req(2'd3, 64'd99, 1, 0, 0, 1, 0), "+99"},
      '{make_req(i2a_pkg::RADIX_HEX, 64'hDEAD_BEEF, 1, 0, 31, 1, 0), "DEADBEEF"},
      '{make_req(i2a_pkg::RADIX_HEX, 64'hDEAD_BEEF, 0, 0, 31, 0, 1), "deadbeef"},
      '{make_req(i2a_pkg::RADIX_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1, 31, 31, 0, 0),
        "FFFFFFFFFFFFFFFF"},
      '{make_req(i2a_pkg::RADIX_HEX, 64'hABC, 0, 0, 0, 0, 0), "c"},
      '{make_req(i2a_pkg::RADIX_HEX, 64'h0, 0, 4, 2, 0, 0), "0000"},
      '{make_req(i2a_pkg::RADIX_OCT, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 31, 0, 0),
        "1777777777777777777777"},
      '{make_req(i2a_pkg::RADIX_OCT, 64'o17, 0, 0, 0, 1, 0), "7"},
      '{make_req(i2a_pkg::RADIX_OCT, 64'o17, 0, 3, 22, 0, 0), "017"},
      '{make_req(i2a_pkg::RADIX_OCT, 64'h0, 0, 31, 0, 0, 0), "0000000000000000000000"},
      '{make_req(i2a_pkg::RADIX_DEC, 64'd1000000000000000000, 0, 0, 0, 0, 0), ""},
      '{make_req(i2a_pkg::RADIX_HEX, 64'h0123_4567_89AB_CDEF, 0, 1, 16, 0, 0), ""}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) send_request(directed_rows[i].req, directed_rows[i].text);
    // Long stretch without gaps in the middle of the random part is left to
    // the gap distribution, which gives no gap nine times in twenty.
    repeat (110) send_request(random_req(), "");
    start <= 1'b0;
    drain = 0;
    while (pending_chars.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (error_count == 0 && pending_chars.size() == 0) begin
      $display("integer_to_ascii_formatter test passed");
    end else begin
      $display("integer_to_ascii_formatter test failed");
    end
    $finish;
  end

endmodule
